### rtl/bfec_pkg.sv
// Shared constants, word types and codes of the clamp-to-edge box filter.
package bfec_pkg;

    // Frame store and kernel limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_KERNEL = 31;

    // Fixed field widths
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int PIXEL_W     = NUM_CHAN * CHAN_W;
    localparam int COORD_IN_W  = 8;
    localparam int SIZE_W      = 9;
    localparam int KERN_W      = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    // Derived widths
    localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int C_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int POS_W    = $clog2(MAX_DIM + MAX_KERNEL) + 2;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AREA_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SUM_W    = $clog2(MAX_KERNEL * MAX_KERNEL * ((1 << CHAN_W) - 1) + 1);
    localparam int DIV_W    = (SUM_W + 1 > AREA_W + CHAN_W) ? SUM_W + 1 : AREA_W + CHAN_W;

    typedef enum logic [0:0] {
        CMD_STORE   = 1'b0,
        CMD_COMPUTE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ZERO_SIZE  = 2'd1,
        STATUS_BAD_KERNEL = 2'd2,
        STATUS_OUTSIDE    = 2'd3
    } status_t;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROI_OFFSET_X  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROI_OFFSET_Y  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_ALPHA    = 3'd6;

    typedef struct packed {
        command_t              command;
        logic [COORD_IN_W-1:0] coord_x;
        logic [COORD_IN_W-1:0] coord_y;
        logic [CHAN_W-1:0]     in_chan0;
        logic [CHAN_W-1:0]     in_chan1;
        logic [CHAN_W-1:0]     in_chan2;
        logic [CHAN_W-1:0]     in_chan3;
    } in_word_t;

    typedef struct packed {
        status_t               status;
        logic [COORD_IN_W-1:0] out_x;
        logic [COORD_IN_W-1:0] out_y;
        logic [CHAN_W-1:0]     out_chan0;
        logic [CHAN_W-1:0]     out_chan1;
        logic [CHAN_W-1:0]     out_chan2;
        logic [CHAN_W-1:0]     out_chan3;
    } out_word_t;

endpackage

### rtl/bfec_ram.sv
// Generic simple dual-port RAM with registered read data.
module bfec_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 65536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/bfec_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded window mean.
module bfec_div import bfec_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [AREA_W-1:0] divisor,
    output logic              done,
    output logic [CHAN_W-1:0] quotient
);

    localparam int STEP_W = (CHAN_W > 1) ? $clog2(CHAN_W) : 1;

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic [DIV_W-1:0]  rem_reg,  rem_next;
    logic [DIV_W-1:0]  dsr_reg,  dsr_next;
    logic [CHAN_W-1:0] quot_reg, quot_next;

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        if (start) begin
            run_next  = 1'b1;
            cnt_next  = STEP_W'(CHAN_W - 1);
            rem_next  = dividend;
            dsr_next  = DIV_W'(divisor) << (CHAN_W - 1);
            quot_next = '0;
        end else if (run_reg) begin
            // trial subtract, shift in one quotient bit
            if (rem_reg >= dsr_reg) begin
                rem_next  = rem_reg - dsr_reg;
                quot_next = {quot_reg[CHAN_W-2:0], 1'b1};
            end else begin
                quot_next = {quot_reg[CHAN_W-2:0], 1'b0};
            end
            dsr_next = dsr_reg >> 1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/box_filter_edge_clamp_argb8_core.sv
// Box filter core: clamp-to-edge window mean over a four-channel 8-bit frame store.
//
// A store word writes one source pixel into the frame store in its accepting
// cycle (ignored when outside the configured source size) and returns nothing. A
// compute word names a destination pixel; the core walks the window around
// the source centre (destination plus ROI offset) one frame store read per
// cycle, clamping coordinates to the image edges, then divides the four
// channel sums by the window area with four bit-serial dividers. A compute
// word holds off the next word through the window walk over the single read
// port of the frame store and the eight-step divide, or only through the checks
// when it fails them, until its result enters the output register. The result
// waits there, so the next word is taken while it waits. Reading a pixel that
// was never stored returns whatever the RAM holds. Configuration is to be
// written only while the core is idle; the core does not enforce this.
module box_filter_edge_clamp_argb8_core import bfec_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    localparam int CEN_W = COORD_IN_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WINDOW,
        ST_DRAIN,
        ST_CENTRE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [SIZE_W-1:0]     src_w_reg;
    logic [SIZE_W-1:0]     src_h_reg;
    logic [COORD_IN_W-1:0] roi_x_reg;
    logic [COORD_IN_W-1:0] roi_y_reg;
    logic [KERN_W-1:0]     win_w_reg;
    logic [KERN_W-1:0]     win_h_reg;
    logic                  keep_alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg      <= SIZE_W'(256);
            src_h_reg      <= SIZE_W'(256);
            roi_x_reg      <= '0;
            roi_y_reg      <= '0;
            win_w_reg      <= KERN_W'(1);
            win_h_reg      <= KERN_W'(1);
            keep_alpha_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_reg      <= cfg_wdata[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: src_h_reg      <= cfg_wdata[SIZE_W-1:0];
                REG_ROI_OFFSET_X:  roi_x_reg      <= cfg_wdata[COORD_IN_W-1:0];
                REG_ROI_OFFSET_Y:  roi_y_reg      <= cfg_wdata[COORD_IN_W-1:0];
                REG_WINDOW_WIDTH:  win_w_reg      <= cfg_wdata[KERN_W-1:0];
                REG_WINDOW_HEIGHT: win_h_reg      <= cfg_wdata[KERN_W-1:0];
                REG_KEEP_ALPHA:    keep_alpha_reg <= cfg_wdata[0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // Saturate the source size to the frame store geometry
    logic [DIM_W-1:0] used_w, used_h;

    assign used_w = (int'(src_w_reg) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : DIM_W'(src_w_reg);
    assign used_h = (int'(src_h_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(src_h_reg);

    // Clamp a signed window coordinate into [0, limit-1]
    function automatic logic [C_W-1:0] clamp_pos(input logic signed [POS_W-1:0] pos,
                                                 input logic [DIM_W-1:0] limit);
        logic [C_W-1:0] res;
        if (pos < 0) begin
            res = '0;
        end else if (int'(pos) >= int'(limit)) begin
            res = C_W'(limit - 1'b1);
        end else begin
            res = C_W'(pos);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [C_W-1:0] sx,
                                                  input logic [C_W-1:0] sy);
        return ADDR_W'(sy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx);
    endfunction

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    state_t                   state_reg,    state_next;
    in_word_t                 item_reg,     item_next;
    status_t                  status_reg,   status_next;
    logic [CEN_W-1:0]         cx_reg,       cx_next;
    logic [CEN_W-1:0]         cy_reg,       cy_next;
    logic [KERN_W-1:0]        kx_reg,       kx_next;
    logic [KERN_W-1:0]        ky_reg,       ky_next;
    logic signed [POS_W-1:0]  px_reg,       px_next;
    logic signed [POS_W-1:0]  py_reg,       py_next;
    logic [AREA_W-1:0]        area_reg,     area_next;
    logic                     rd_vld_reg,   rd_vld_next;
    logic [SUM_W-1:0]         sum_reg  [NUM_CHAN];
    logic [SUM_W-1:0]         sum_next [NUM_CHAN];
    logic [CHAN_W-1:0]        alpha_reg,    alpha_next;
    logic                     m_valid_reg,  m_valid_next;
    out_word_t                m_data_reg,   m_data_next;

    // Frame store
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [PIXEL_W-1:0]       ram_wr_data;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [PIXEL_W-1:0]       ram_rd_data;

    // Dividers
    logic                     div_start;
    logic [NUM_CHAN-1:0]      div_done;
    logic [CHAN_W-1:0]        div_quot [NUM_CHAN];

    // Per-item checks, evaluated on the held word
    logic [CEN_W-1:0]         cx_calc, cy_calc;
    logic                     kern_bad;
    status_t                  status_calc;

    assign cx_calc = CEN_W'(roi_x_reg) + CEN_W'(item_reg.coord_x);
    assign cy_calc = CEN_W'(roi_y_reg) + CEN_W'(item_reg.coord_y);

    assign kern_bad = (win_w_reg == '0) || (win_h_reg == '0)
                   || !win_w_reg[0] || !win_h_reg[0]
                   || (int'(win_w_reg) > MAX_KERNEL) || (int'(win_h_reg) > MAX_KERNEL);

    always_comb begin
        if (used_w == '0 || used_h == '0) begin
            status_calc = STATUS_ZERO_SIZE;
        end else if (kern_bad) begin
            status_calc = STATUS_BAD_KERNEL;
        end else if (int'(cx_calc) >= int'(used_w) || int'(cy_calc) >= int'(used_h)) begin
            status_calc = STATUS_OUTSIDE;
        end else begin
            status_calc = STATUS_OK;
        end
    end

    // Store path: write the frame store in the accepting cycle
    logic s_accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign ram_we      = s_accept && (s_data.command == CMD_STORE)
                      && (int'(s_data.coord_x) < int'(used_w))
                      && (int'(s_data.coord_y) < int'(used_h));
    assign ram_wr_addr = addr_of(C_W'(s_data.coord_x), C_W'(s_data.coord_y));
    assign ram_wr_data = {s_data.in_chan3, s_data.in_chan2, s_data.in_chan1, s_data.in_chan0};

    // Read path: window walk, then one read of the centre for the alpha copy
    assign ram_rd_addr = (state_reg == ST_WINDOW)
                       ? addr_of(clamp_pos(px_reg, used_w), clamp_pos(py_reg, used_h))
                       : addr_of(C_W'(cx_reg), C_W'(cy_reg));

    bfec_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign div_start = (state_reg == ST_CENTRE);

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_div
        bfec_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (DIV_W'(sum_reg[c]) + DIV_W'(area_reg >> 1)),
            .divisor  (area_reg),
            .done     (div_done[c]),
            .quotient (div_quot[c])
        );
    end

    // ---------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        status_next  = status_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        kx_next      = kx_reg;
        ky_next      = ky_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        area_next    = area_reg;
        rd_vld_next  = 1'b0;
        alpha_next   = alpha_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        // accumulate the word that the previous cycle read
        for (int c = 0; c < NUM_CHAN; c++) begin
            sum_next[c] = sum_reg[c];
            if (rd_vld_reg) begin
                sum_next[c] = sum_reg[c] + SUM_W'(ram_rd_data[c*CHAN_W +: CHAN_W]);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    item_next = s_data;
                    if (s_data.command == CMD_COMPUTE) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // latch status, centre and window start; clear the sums
                status_next = status_calc;
                cx_next     = cx_calc;
                cy_next     = cy_calc;
                kx_next     = '0;
                ky_next     = '0;
                px_next     = POS_W'(cx_calc) - POS_W'(win_w_reg >> 1);
                py_next     = POS_W'(cy_calc) - POS_W'(win_h_reg >> 1);
                area_next   = AREA_W'(win_w_reg) * AREA_W'(win_h_reg);
                for (int c = 0; c < NUM_CHAN; c++) begin
                    sum_next[c] = '0;
                end
                state_next = (status_calc == STATUS_OK) ? ST_WINDOW : ST_DONE;
            end
            ST_WINDOW: begin
                // one read per cycle, row by row
                rd_vld_next = 1'b1;
                if (kx_reg == win_w_reg - 1'b1) begin
                    kx_next = '0;
                    px_next = POS_W'(cx_reg) - POS_W'(win_w_reg >> 1);
                    if (ky_reg == win_h_reg - 1'b1) begin
                        state_next = ST_DRAIN;
                    end else begin
                        ky_next = ky_reg + 1'b1;
                        py_next = py_reg + 1'b1;
                    end
                end else begin
                    kx_next = kx_reg + 1'b1;
                    px_next = px_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last window word lands; centre read goes out
                state_next = ST_CENTRE;
            end
            ST_CENTRE: begin
                alpha_next = ram_rd_data[CHAN_W-1:0];
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done[0]) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.out_x     = item_reg.coord_x;
                    m_data_next.out_y     = item_reg.coord_y;
                    if (status_reg == STATUS_OK) begin
                        m_data_next.out_chan0 = keep_alpha_reg ? alpha_reg : div_quot[0];
                        m_data_next.out_chan1 = div_quot[1];
                        m_data_next.out_chan2 = div_quot[2];
                        m_data_next.out_chan3 = div_quot[3];
                    end else begin
                        m_data_next.out_chan0 = '0;
                        m_data_next.out_chan1 = '0;
                        m_data_next.out_chan2 = '0;
                        m_data_next.out_chan3 = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        status_reg <= status_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        kx_reg     <= kx_next;
        ky_reg     <= ky_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        area_reg   <= area_next;
        alpha_reg  <= alpha_next;
        m_data_reg <= m_data_next;
        for (int c = 0; c < NUM_CHAN; c++) begin
            sum_reg[c] <= sum_next[c];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_div_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done[0] |-> (&div_done))
        else $error("divider lanes finished out of step");

    a_error_zero_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |->
        (m_data.out_chan0 == '0 && m_data.out_chan1 == '0
         && m_data.out_chan2 == '0 && m_data.out_chan3 == '0))
        else $error("error result carries nonzero channels");

    a_drain_after_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |->
        ($past(state_reg) == ST_WINDOW && $past(ky_reg) == win_h_reg - 1'b1
         && $past(kx_reg) == win_w_reg - 1'b1))
        else $error("window walk ended before the last window word");

endmodule

### tb/bfec_result_checker.sv
// Result checker of the box filter core: predicts every result word and compares it on arrival.
`timescale 1ns / 100ps
module bfec_result_checker import bfec_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_word_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_word_t              m_data,
    output int                     pending_results,
    output int                     mismatch_count
);

    // Own copy of the frame and of the register file
    logic [PIXEL_W-1:0] frame_copy [0:DEPTH-1];
    logic [SIZE_W-1:0]  src_w;
    logic [SIZE_W-1:0]  src_h;
    logic [7:0]         roi_x;
    logic [7:0]         roi_y;
    logic [KERN_W-1:0]  win_w;
    logic [KERN_W-1:0]  win_h;
    logic               keep_alpha;

    out_word_t mean_pixel_q [$];
    int        mismatches = 0;

    function automatic int edge_pos(input int centre, input int k, input int radius,
                                    input int limit);
        int pos;
        pos = centre + k - radius;
        if (pos < 0)
            pos = 0;
        if (pos >= limit)
            pos = limit - 1;
        return pos;
    endfunction

    function automatic out_word_t predict_box_mean(input in_word_t w);
        out_word_t          r;
        int                 uw;
        int                 uh;
        int                 cx;
        int                 cy;
        int                 sx;
        int                 sy;
        int                 area;
        int                 sums [NUM_CHAN];
        int                 mean [NUM_CHAN];
        logic [PIXEL_W-1:0] px;
        uw = (src_w > MAX_WIDTH) ? MAX_WIDTH : src_w;
        uh = (src_h > MAX_HEIGHT) ? MAX_HEIGHT : src_h;
        r = '0;
        r.out_x = w.coord_x;
        r.out_y = w.coord_y;
        if (uw == 0 || uh == 0) begin
            r.status = STATUS_ZERO_SIZE;
        end else if (win_w == 0 || win_h == 0 || !win_w[0] || !win_h[0]
                     || win_w > MAX_KERNEL || win_h > MAX_KERNEL) begin
            r.status = STATUS_BAD_KERNEL;
        end else begin
            cx = roi_x + w.coord_x;
            cy = roi_y + w.coord_y;
            if (cx >= uw || cy >= uh) begin
                r.status = STATUS_OUTSIDE;
            end else begin
                r.status = STATUS_OK;
                area = win_w * win_h;
                for (int c = 0; c < NUM_CHAN; c++)
                    sums[c] = 0;
                for (int ky = 0; ky < win_h; ky++) begin
                    sy = edge_pos(cy, ky, win_h / 2, uh);
                    for (int kx = 0; kx < win_w; kx++) begin
                        sx = edge_pos(cx, kx, win_w / 2, uw);
                        px = frame_copy[sy * MAX_WIDTH + sx];
                        for (int c = 0; c < NUM_CHAN; c++)
                            sums[c] += px[c * CHAN_W +: CHAN_W];
                    end
                end
                for (int c = 0; c < NUM_CHAN; c++)
                    mean[c] = (sums[c] + area / 2) / area;
                r.out_chan0 = mean[0][CHAN_W-1:0];
                r.out_chan1 = mean[1][CHAN_W-1:0];
                r.out_chan2 = mean[2][CHAN_W-1:0];
                r.out_chan3 = mean[3][CHAN_W-1:0];
                // Alpha bypass takes the centre pixel as it is
                if (keep_alpha)
                    r.out_chan0 = frame_copy[cy * MAX_WIDTH + cx][CHAN_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_word_t want;
        bit        bad;
        if (!aresetn) begin
            src_w      = SIZE_W'(MAX_WIDTH);
            src_h      = SIZE_W'(MAX_HEIGHT);
            roi_x      = '0;
            roi_y      = '0;
            win_w      = KERN_W'(1);
            win_h      = KERN_W'(1);
            keep_alpha = 1'b0;
            mean_pixel_q.delete();
        end else begin
            // Check the result word first; its expectation was queued when the compute word was accepted
            if (m_valid && m_ready) begin
                if (mean_pixel_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("UNEXPECTED result word at %0t: st=%0d x=%0d y=%0d",
                                 $time, m_data.status, m_data.out_x, m_data.out_y);
                    mismatches++;
                end else begin
                    want = mean_pixel_q.pop_front();
                    bad = (m_data.status !== want.status) || (m_data.out_x !== want.out_x)
                        || (m_data.out_y !== want.out_y)
                        || (m_data.out_chan0 !== want.out_chan0)
                        || (m_data.out_chan1 !== want.out_chan1)
                        || (m_data.out_chan2 !== want.out_chan2)
                        || (m_data.out_chan3 !== want.out_chan3);
                    if (bad) begin
                        if (mismatches < 10)
                            $display({"MISMATCH at %0t: expected st=%0d x=%0d y=%0d ",
                                      "ch=%h %h %h %h, got st=%0d x=%0d y=%0d ch=%h %h %h %h"},
                                     $time, want.status, want.out_x, want.out_y,
                                     want.out_chan0, want.out_chan1, want.out_chan2,
                                     want.out_chan3, m_data.status, m_data.out_x,
                                     m_data.out_y, m_data.out_chan0, m_data.out_chan1,
                                     m_data.out_chan2, m_data.out_chan3);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.command == CMD_STORE) begin
                    if (s_data.coord_x < ((src_w > MAX_WIDTH) ? MAX_WIDTH : src_w)
                        && s_data.coord_y < ((src_h > MAX_HEIGHT) ? MAX_HEIGHT : src_h))
                        frame_copy[s_data.coord_y * MAX_WIDTH + s_data.coord_x] =
                            {s_data.in_chan3, s_data.in_chan2, s_data.in_chan1,
                             s_data.in_chan0};
                end else begin
                    mean_pixel_q.push_back(predict_box_mean(s_data));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w      = cfg_wdata;
                    REG_SOURCE_HEIGHT: src_h      = cfg_wdata;
                    REG_ROI_OFFSET_X:  roi_x      = cfg_wdata[7:0];
                    REG_ROI_OFFSET_Y:  roi_y      = cfg_wdata[7:0];
                    REG_WINDOW_WIDTH:  win_w      = cfg_wdata[KERN_W-1:0];
                    REG_WINDOW_HEIGHT: win_h      = cfg_wdata[KERN_W-1:0];
                    REG_KEEP_ALPHA:    keep_alpha = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending_results <= mean_pixel_q.size();
        mismatch_count  <= mismatches;
    end

endmodule

### tb/testbench.sv
// Top of the box filter core testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps
module testbench;
    import bfec_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;
    // A store may still be in flight once the last result has left
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 620;
    localparam int HOLD_CYCLES   = 700;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    in_word_t               s_data    = '0;
    logic                   m_ready   = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    out_word_t              m_data;

    int pending_results;
    int mismatch_count;
    int cycle_count = 0;

    // Stimulus side view of the frame and the setting in force
    bit written [0:DEPTH-1];
    int used_w      = MAX_WIDTH;
    int used_h      = MAX_HEIGHT;
    int roi_x_now   = 0;
    int roi_y_now   = 0;
    int taken_items = 0;
    int rand_count  = 0;
    bit burst_mode  = 1'b0;

    // Result sink state
    bit sink_hold_req = 1'b0;
    int sink_run      = 0;
    int sink_stall    = 0;

    box_filter_edge_clamp_argb8_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    bfec_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("box_filter_edge_clamp_argb8_core test failed");
            $finish;
        end
    end

    // Result sink: runs of ready, short and long stalls, and one long hold on request
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_hold_req) begin
            // Hold off long enough for the core to fill and back up its input
            sink_hold_req = 1'b0;
            sink_stall    = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if (sink_run > 0) begin
            sink_run--;
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                sink_run = (r < 10) ? $urandom_range(40, 200) : $urandom_range(1, 8);
                m_ready <= 1'b1;
            end else begin
                sink_stall = (r < 96) ? $urandom_range(1, 4) : $urandom_range(20, 100);
                m_ready <= 1'b0;
            end
        end
    end

    // Gap before the next input word: mostly none, a few long ones
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Offer one input word and hold it until the core takes it.
    // Called at a clock edge; returns at the edge that accepts the word.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Store one pixel; track what the core has really kept
    task automatic store_pixel(input int x, input int y, input logic [PIXEL_W-1:0] px);
        in_word_t w;
        w.command  = CMD_STORE;
        w.coord_x  = x[7:0];
        w.coord_y  = y[7:0];
        w.in_chan0 = px[7:0];
        w.in_chan1 = px[15:8];
        w.in_chan2 = px[23:16];
        w.in_chan3 = px[31:24];
        send_word(w);
        taken_items++;
        if (x < used_w && y < used_h)
            written[y * MAX_WIDTH + x] = 1'b1;
    endtask

    // Ask for one destination pixel; the pixel fields carry noise
    task automatic compute_pixel(input int x, input int y);
        in_word_t w;
        w.command  = CMD_COMPUTE;
        w.coord_x  = x[7:0];
        w.coord_y  = y[7:0];
        w.in_chan0 = CHAN_W'($urandom_range(0, 255));
        w.in_chan1 = CHAN_W'($urandom_range(0, 255));
        w.in_chan2 = CHAN_W'($urandom_range(0, 255));
        w.in_chan3 = CHAN_W'($urandom_range(0, 255));
        send_word(w);
        taken_items++;
    endtask

    // Write one register; only called while the core is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        s_valid   <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  used_w    = (val > MAX_WIDTH) ? MAX_WIDTH : val;
            REG_SOURCE_HEIGHT: used_h    = (val > MAX_HEIGHT) ? MAX_HEIGHT : val;
            REG_ROI_OFFSET_X:  roi_x_now = val;
            REG_ROI_OFFSET_Y:  roi_y_now = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Drop valid, wait for every expected result, then let stores drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write every pixel of the source area not yet written, so no window reads garbage
    task automatic fill_region();
        for (int y = 0; y < used_h; y++)
            for (int x = 0; x < used_w; x++)
                if (!written[y * MAX_WIDTH + x])
                    store_pixel(x, y, $urandom);
    endtask

    // Pick a new setting: mostly small images, a few full-width or full-height strips,
    // some zero sizes and bad windows
    task automatic choose_setting();
        int r;
        int w;
        int h;
        int kw;
        int kh;
        int t;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            w = $urandom_range(256, 511);
            h = $urandom_range(1, 2);
        end else if (r < 20) begin
            w = $urandom_range(1, 2);
            h = $urandom_range(256, 511);
        end else if (r < 25) begin
            w = $urandom_range(0, 16);
            h = (w == 0) ? $urandom_range(0, 16) : 0;
        end else begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 16);
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            kw = 2 * $urandom_range(0, 15);
            kh = $urandom_range(0, 31);
            if ($urandom_range(0, 1)) begin
                t  = kw;
                kw = kh;
                kh = t;
            end
        end else if (r < 16) begin
            kw = 2 * $urandom_range(0, 15) + 1;
            kh = 2 * $urandom_range(0, 15) + 1;
        end else begin
            kw = 2 * $urandom_range(0, 3) + 1;
            kh = 2 * $urandom_range(0, 3) + 1;
        end
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        r = $urandom_range(0, 99);
        if (r < 40 || used_w == 0)
            t = (r < 85) ? 0 : $urandom_range(0, 255);
        else
            t = (r < 85) ? $urandom_range(0, used_w - 1) : $urandom_range(0, 255);
        write_reg(REG_ROI_OFFSET_X, t);
        r = $urandom_range(0, 99);
        if (r < 40 || used_h == 0)
            t = (r < 85) ? 0 : $urandom_range(0, 255);
        else
            t = (r < 85) ? $urandom_range(0, used_h - 1) : $urandom_range(0, 255);
        write_reg(REG_ROI_OFFSET_Y, t);
        write_reg(REG_WINDOW_WIDTH, kw);
        write_reg(REG_WINDOW_HEIGHT, kh);
        write_reg(REG_KEEP_ALPHA, $urandom_range(0, 1));
    endtask

    initial begin
        int n0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Opposite corners of the full frame at the reset setting (1x1 window)
        store_pixel(0, 0, 32'hFF00FF00);
        store_pixel(255, 255, 32'h00FF00FF);
        compute_pixel(0, 0);
        compute_pixel(255, 255);
        settle();

        // Zero width is reported ahead of a bad window
        write_reg(REG_SOURCE_WIDTH, 0);
        write_reg(REG_WINDOW_WIDTH, 2);
        compute_pixel(0, 0);
        settle();

        // Oversized width saturates; the even window shows up now
        write_reg(REG_SOURCE_WIDTH, 511);
        compute_pixel(0, 0);
        settle();
        write_reg(REG_WINDOW_WIDTH, 0);
        compute_pixel(0, 0);
        settle();

        // Bad window height beats a centre off the right edge
        write_reg(REG_WINDOW_WIDTH, 1);
        write_reg(REG_WINDOW_HEIGHT, 30);
        write_reg(REG_ROI_OFFSET_X, 255);
        compute_pixel(1, 0);
        settle();

        // Centre one past the right edge, then the far corner through the offset
        write_reg(REG_WINDOW_HEIGHT, 1);
        compute_pixel(1, 0);
        compute_pixel(0, 255);
        settle();

        // Zero height
        write_reg(REG_SOURCE_HEIGHT, 0);
        compute_pixel(0, 0);
        settle();

        // Oversized height saturates; centre one past the bottom edge
        write_reg(REG_SOURCE_HEIGHT, 300);
        write_reg(REG_ROI_OFFSET_X, 0);
        write_reg(REG_ROI_OFFSET_Y, 255);
        compute_pixel(0, 1);
        settle();

        // Tiny image: stores just outside are dropped, windows clamp at the edges
        write_reg(REG_ROI_OFFSET_Y, 0);
        write_reg(REG_SOURCE_WIDTH, 3);
        write_reg(REG_SOURCE_HEIGHT, 3);
        store_pixel(3, 0, $urandom);
        store_pixel(0, 3, $urandom);
        fill_region();
        write_reg(REG_WINDOW_WIDTH, 3);
        write_reg(REG_WINDOW_HEIGHT, 3);
        compute_pixel(0, 0);
        settle();
        write_reg(REG_KEEP_ALPHA, 1);
        compute_pixel(1, 1);
        settle();
        write_reg(REG_WINDOW_WIDTH, 31);
        write_reg(REG_WINDOW_HEIGHT, 31);
        compute_pixel(2, 0);
        settle();

        // A write to the unused index must leave the setting alone
        write_reg(REG_UNUSED, 9'h1FF);
        compute_pixel(1, 1);
        settle();

        // Back-pressure: hold the sink while offering cheap computes
        write_reg(REG_WINDOW_WIDTH, 1);
        write_reg(REG_WINDOW_HEIGHT, 1);
        sink_hold_req = 1'b1;
        n0 = taken_items;
        repeat (16) compute_pixel($urandom_range(0, 2), $urandom_range(0, 2));
        rand_count += taken_items - n0;
        settle();

        // Random phases: new setting, fill the area, then a mix of stores and computes
        while (rand_count < RANDOM_ITEMS) begin
            n0 = taken_items;
            choose_setting();
            fill_region();
            burst_mode = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 50)) begin
                if ($urandom_range(0, 99) < 35) begin
                    if (used_w > 0 && used_h > 0 && $urandom_range(0, 99) < 85)
                        store_pixel($urandom_range(0, used_w - 1),
                                    $urandom_range(0, used_h - 1), $urandom);
                    else
                        store_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom);
                end else begin
                    if (used_w > roi_x_now && used_h > roi_y_now
                        && $urandom_range(0, 99) < 80)
                        compute_pixel($urandom_range(0, used_w - 1 - roi_x_now),
                                      $urandom_range(0, used_h - 1 - roi_y_now));
                    else
                        compute_pixel($urandom_range(0, 255), $urandom_range(0, 255));
                end
            end
            rand_count += taken_items - n0;
            burst_mode = 1'b0;
            settle();
        end

        // Everything has arrived; give the core a little longer before the verdict
        settle();
        if (mismatch_count == 0)
            $display("box_filter_edge_clamp_argb8_core test passed");
        else
            $display("box_filter_edge_clamp_argb8_core test failed");
        $finish;
    end

endmodule
